[src/nwk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwk_pkg
// Shared types, constants and a helper function for the number-to-word-keys unit.
// ----------------------------------------------------------------------------
package nwk_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned KEY_W   = 30;
  localparam int unsigned DIGITS  = 10;
  localparam int unsigned BCD_W   = 4 * DIGITS;
  localparam int unsigned CNT_W   = 5;

  localparam logic [CNT_W-1:0] LAST_SHIFT = CNT_W'(VALUE_W - 1);

  localparam logic [KEY_W-1:0] KEY_HUNDRED  = KEY_W'(100);
  localparam logic [KEY_W-1:0] KEY_THOUSAND = KEY_W'(1000);
  localparam logic [KEY_W-1:0] KEY_MILLION  = KEY_W'(1000000);
  localparam logic [KEY_W-1:0] KEY_BILLION  = KEY_W'(1000000000);
  localparam logic [KEY_W-1:0] KEY_ZERO     = '0;

  localparam logic [1:0] GRP_UNITS     = 2'd0;
  localparam logic [1:0] GRP_THOUSANDS = 2'd1;
  localparam logic [1:0] GRP_MILLIONS  = 2'd2;
  localparam logic [1:0] GRP_BILLIONS  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    PH_HUND,
    PH_CENT,
    PH_TENS,
    PH_UNIT,
    PH_SCALE
  } phase_t;

  typedef struct packed {
    logic             present;
    logic [KEY_W-1:0] key;
  } key_sel_t;

  // Tens digit times ten
  function automatic logic [6:0] tens_key(input logic [3:0] t);
    logic [6:0] k;
    begin
      case (t)
        4'd1:    k = 7'd10;
        4'd2:    k = 7'd20;
        4'd3:    k = 7'd30;
        4'd4:    k = 7'd40;
        4'd5:    k = 7'd50;
        4'd6:    k = 7'd60;
        4'd7:    k = 7'd70;
        4'd8:    k = 7'd80;
        4'd9:    k = 7'd90;
        default: k = 7'd0;
      endcase
      return k;
    end
  endfunction

endpackage
`default_nettype wire

[src/nwk_bcd_conv.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwk_bcd_conv
// Iterative binary-to-BCD converter: one shift-and-add-3 step per cycle.
// ----------------------------------------------------------------------------
module nwk_bcd_conv (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [nwk_pkg::VALUE_W-1:0]    value,
  output logic                                done,
  output logic      [nwk_pkg::BCD_W-1:0]      bcd
);

  logic [nwk_pkg::VALUE_W-1:0] bin;
  logic [nwk_pkg::CNT_W-1:0]   cnt;
  logic                        running;
  logic [nwk_pkg::BCD_W-1:0]   adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < nwk_pkg::DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == nwk_pkg::LAST_SHIFT);
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == nwk_pkg::LAST_SHIFT) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (running) begin
      bin <= {bin[nwk_pkg::VALUE_W-2:0], 1'b0};
      bcd <= {adj[nwk_pkg::BCD_W-2:0], bin[nwk_pkg::VALUE_W-1]};
    end
  end

endmodule
`default_nettype wire

[src/nwk_key_sel.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwk_key_sel
// Picks the word key, if any, for one phase of one three-digit group.
// ----------------------------------------------------------------------------
module nwk_key_sel (
  input  wire logic [nwk_pkg::BCD_W-1:0] bcd,
  input  wire logic [1:0]                grp,
  input  wire nwk_pkg::phase_t           phase,
  output nwk_pkg::key_sel_t              sel
);

  logic [3:0] h, t, u;
  logic       nonzero;
  logic [6:0] small_key;
  logic [nwk_pkg::KEY_W-1:0] scale;

  always_comb begin
    unique case (grp)
      nwk_pkg::GRP_UNITS: begin
        h = bcd[11:8];  t = bcd[7:4];   u = bcd[3:0];
        scale = nwk_pkg::KEY_ZERO;
      end
      nwk_pkg::GRP_THOUSANDS: begin
        h = bcd[23:20]; t = bcd[19:16]; u = bcd[15:12];
        scale = nwk_pkg::KEY_THOUSAND;
      end
      nwk_pkg::GRP_MILLIONS: begin
        h = bcd[35:32]; t = bcd[31:28]; u = bcd[27:24];
        scale = nwk_pkg::KEY_MILLION;
      end
      default: begin
        h = 4'd0;       t = 4'd0;       u = bcd[39:36];
        scale = nwk_pkg::KEY_BILLION;
      end
    endcase
  end

  assign nonzero = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);

  always_comb begin
    small_key = nwk_pkg::tens_key(t);
    sel       = '0;
    unique case (phase)
      nwk_pkg::PH_HUND: begin
        sel.present = (h != 4'd0);
        sel.key     = nwk_pkg::KEY_W'(h);
      end
      nwk_pkg::PH_CENT: begin
        sel.present = (h != 4'd0);
        sel.key     = nwk_pkg::KEY_HUNDRED;
      end
      nwk_pkg::PH_TENS: begin
        // Twenty and up: tens key only; below twenty: one key 1..19
        if (t >= 4'd2) begin
          sel.present = 1'b1;
          sel.key     = nwk_pkg::KEY_W'(small_key);
        end else begin
          sel.present = (t != 4'd0) || (u != 4'd0);
          sel.key     = nwk_pkg::KEY_W'(small_key + 7'(u));
        end
      end
      nwk_pkg::PH_UNIT: begin
        sel.present = (t >= 4'd2) && (u != 4'd0);
        sel.key     = nwk_pkg::KEY_W'(u);
      end
      nwk_pkg::PH_SCALE: begin
        sel.present = nonzero && (grp != nwk_pkg::GRP_UNITS);
        sel.key     = scale;
      end
      default: begin
        sel = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/number_to_word_keys_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// number_to_word_keys_unit
// Spells an unsigned 32-bit number as a stream of English word keys.
// ----------------------------------------------------------------------------
// Each accepted number is turned into ten decimal digits by a shift-and-add-3
// converter that takes one bit per cycle (32 shifts, then a registered done
// flag). A sequencer then walks the billions, millions, thousands and units
// groups, five phases per group (hundreds digit, hundred, tens or teen, unit,
// scale), one phase per cycle unless a stalled output holds it. A final
// flush state hands over the held key. Keys leave on the output channel in
// spoken order; the last key of a number has last_word set, and a zero input
// gives the single key 0. One key is held back in a pending register so
// that the final one can be flagged. in_ready falls when a number is
// accepted and rises again once the conversion, the walk and the flush are
// done, so no number is taken while another is being spelled. out_ready low
// stalls the unit only when a new key meets a held key while the output word
// cannot leave, or while the final key waits to go out; a stall during the
// conversion costs nothing. in_ready is high only while the unit is idle.
// The final word of a number may still wait when the next is accepted.
// ----------------------------------------------------------------------------
module number_to_word_keys_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [nwk_pkg::VALUE_W-1:0]   value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [nwk_pkg::KEY_W-1:0]     word_key,
  output logic                               last_word
);

  nwk_pkg::state_t state, state_next;
  nwk_pkg::phase_t phase, phase_next;
  logic [1:0]      grp, grp_next;

  logic [nwk_pkg::KEY_W-1:0] pend, pend_next;
  logic                      pend_valid, pend_valid_next;

  logic                      start;
  logic                      conv_done;
  logic [nwk_pkg::BCD_W-1:0] bcd;
  nwk_pkg::key_sel_t         sel;

  logic                      can_push;
  logic                      push;
  logic [nwk_pkg::KEY_W-1:0] push_key;
  logic                      push_last;

  // Decimal conversion by iterative shift-and-add-3 steps
  nwk_bcd_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (value),
    .done  (conv_done),
    .bcd   (bcd)
  );

  // Key selection for the current group and phase
  nwk_key_sel u_sel (
    .bcd   (bcd),
    .grp   (grp),
    .phase (phase),
    .sel   (sel)
  );

  assign in_ready = (state == nwk_pkg::ST_IDLE);
  assign start    = in_valid && in_ready;
  // The output register can take a word when empty or draining this cycle
  assign can_push = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= nwk_pkg::ST_IDLE;
      phase      <= nwk_pkg::PH_HUND;
      grp        <= nwk_pkg::GRP_BILLIONS;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      grp        <= grp_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    grp_next        = grp;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    push            = 1'b0;
    push_key        = pend;
    push_last       = 1'b0;

    unique case (state)
      nwk_pkg::ST_IDLE: begin
        if (start) begin
          state_next      = nwk_pkg::ST_CONV;
          phase_next      = nwk_pkg::PH_HUND;
          grp_next        = nwk_pkg::GRP_BILLIONS;
          pend_valid_next = 1'b0;
        end
      end
      nwk_pkg::ST_CONV: begin
        if (conv_done) begin
          state_next = nwk_pkg::ST_EMIT;
        end
      end
      nwk_pkg::ST_EMIT: begin
        // Hold the phase while a new key would displace a pending one that
        // cannot leave yet
        if (!(sel.present && pend_valid && !can_push)) begin
          if (sel.present) begin
            push            = pend_valid;
            pend_next       = sel.key;
            pend_valid_next = 1'b1;
          end
          unique case (phase)
            nwk_pkg::PH_HUND:  phase_next = nwk_pkg::PH_CENT;
            nwk_pkg::PH_CENT:  phase_next = nwk_pkg::PH_TENS;
            nwk_pkg::PH_TENS:  phase_next = nwk_pkg::PH_UNIT;
            nwk_pkg::PH_UNIT:  phase_next = nwk_pkg::PH_SCALE;
            nwk_pkg::PH_SCALE: begin
              phase_next = nwk_pkg::PH_HUND;
              if (grp == nwk_pkg::GRP_UNITS) begin
                state_next = nwk_pkg::ST_FLUSH;
              end else begin
                grp_next = grp - 2'd1;
              end
            end
            default: phase_next = nwk_pkg::PH_HUND;
          endcase
        end
      end
      nwk_pkg::ST_FLUSH: begin
        // Drop the held key out as the final word; zero spells as key 0
        if (can_push) begin
          push            = 1'b1;
          push_last       = 1'b1;
          push_key        = pend_valid ? pend : nwk_pkg::KEY_ZERO;
          pend_valid_next = 1'b0;
          state_next      = nwk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nwk_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word_key  <= push_key;
      last_word <= push_last;
    end
  end

endmodule
`default_nettype wire

[src/nwk_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwk_checker
// Port-level checks for the number-to-word-keys unit.
// ----------------------------------------------------------------------------
module nwk_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [nwk_pkg::VALUE_W-1:0] value,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [nwk_pkg::KEY_W-1:0]   word_key,
  input wire logic                        last_word
);

  // A waiting input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(value))
    else $error("input word changed while waiting");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_key) && $stable(last_word))
    else $error("output word changed while stalled");

  // Busy for at least the cycle after a number is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after accept");

  // While idle, any word still waiting must be the final one of its number
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last_word)
    else $error("non-final word pending while idle");

  // Key zero only ever stands alone
  a_zero_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (word_key == nwk_pkg::KEY_ZERO) |-> last_word)
    else $error("key zero not flagged as final");

endmodule

bind number_to_word_keys_unit nwk_checker u_nwk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .value     (value),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .word_key  (word_key),
  .last_word (last_word)
);
`default_nettype wire

[tb/tb_number_to_word_keys_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_number_to_word_keys_unit
// Self-checking bench for the number-to-word-keys unit. A queue of numbers
// (a directed set of edge values followed by random values of assorted
// shapes) feeds a clocked driver; a clocked monitor spells every accepted
// number into the expected word keys and compares each output word, in
// order, against them. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_number_to_word_keys_unit;

  localparam int RANDOM_NUMBERS = 145;
  localparam int CALM_TAIL      = 25;    // final stretch with no idling
  localparam int STUCK_LIMIT    = 3000;  // cycles with no word moving
  localparam int SETTLE_CYCLES  = 80;    // wait out the unit's own latency

  typedef struct {
    logic [nwk_pkg::VALUE_W-1:0] value;
    bit                          drain_first;  // hold the number until all keys are out
  } pending_number_t;

  typedef struct {
    logic [nwk_pkg::KEY_W-1:0] key;
    logic                      is_last;
  } spoken_word_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic [nwk_pkg::VALUE_W-1:0] value     = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b1;
  logic [nwk_pkg::KEY_W-1:0]   word_key;
  logic                        last_word;

  pending_number_t pending_numbers[$];
  spoken_word_t    spoken_keys[$];

  int total_numbers  = 0;
  int sent_count     = 0;  // numbers put on the input channel (driver side)
  int in_count       = 0;  // numbers accepted by the unit (monitor side)
  int words_checked  = 0;
  int fail_count     = 0;
  int stuck_cycles   = 0;

  number_to_word_keys_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .word_key  (word_key),
    .last_word (last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Expected-key builder: spell a number the way the unit should
  // --------------------------------------------------------------------------
  task automatic push_key(input logic [nwk_pkg::KEY_W-1:0] key);
    spoken_keys.push_back('{key: key, is_last: 1'b0});
  endtask

  // Keys of one group 1..999: hundreds digit and 100, then tens and unit or
  // a single key for 1..19. An empty group adds nothing.
  task automatic say_group(input int unsigned grp);
    int unsigned rest;
    rest = grp % 1000;
    if (rest >= 100) begin
      push_key(nwk_pkg::KEY_W'(rest / 100));
      push_key(nwk_pkg::KEY_HUNDRED);
      rest = rest % 100;
    end
    if (rest >= 20) begin
      push_key(nwk_pkg::KEY_W'((rest / 10) * 10));
      if (rest % 10 != 0) push_key(nwk_pkg::KEY_W'(rest % 10));
    end else if (rest > 0) begin
      push_key(nwk_pkg::KEY_W'(rest));
    end
  endtask

  task automatic spell_number(input logic [nwk_pkg::VALUE_W-1:0] num);
    int unsigned rem;
    rem = num;
    if (rem == 0) begin
      push_key(nwk_pkg::KEY_ZERO);
    end else begin
      if (rem >= 1000000000) begin
        say_group(rem / 1000000000);
        push_key(nwk_pkg::KEY_BILLION);
        rem = rem % 1000000000;
      end
      if (rem >= 1000000) begin
        say_group(rem / 1000000);
        push_key(nwk_pkg::KEY_MILLION);
        rem = rem % 1000000;
      end
      if (rem >= 1000) begin
        say_group(rem / 1000);
        push_key(nwk_pkg::KEY_THOUSAND);
        rem = rem % 1000;
      end
      if (rem > 0) say_group(rem);
    end
    // flag the closing key of this number
    spoken_keys[spoken_keys.size()-1].is_last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned random_group();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 999);
  endfunction

  function automatic void add_number(input logic [nwk_pkg::VALUE_W-1:0] num,
                                     input bit drain);
    pending_numbers.push_back('{value: num, drain_first: drain});
  endfunction

  // No idling in a mid-run stretch and over the final numbers of the run
  function automatic bit calm_phase(input int idx);
    return (idx >= 70 && idx < 100) || (idx >= total_numbers - CALM_TAIL);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: change at the falling edge, one word at a time
  // --------------------------------------------------------------------------
  int in_gap = 0;

  always @(negedge clk) begin
    pending_number_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_count != sent_count) begin
      // hold the word until it is taken
    end else if (in_gap > 0) begin
      in_gap   = in_gap - 1;
      in_valid <= 1'b0;
    end else if (!calm_phase(sent_count) && $urandom_range(0, 5) == 0) begin
      in_gap   = $urandom_range(1, 17) - 1;
      in_valid <= 1'b0;
    end else if (pending_numbers.size() != 0 &&
                 !(pending_numbers[0].drain_first && spoken_keys.size() != 0)) begin
      nxt        = pending_numbers.pop_front();
      in_valid   <= 1'b1;
      value      <= nxt.value;
      sent_count = sent_count + 1;
    end else begin
      // nothing to send, or waiting for the output side to drain
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Output back-pressure: random stall bursts on out_ready
  // --------------------------------------------------------------------------
  int out_stall = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_ready <= 1'b0;
    end else if (!calm_phase(in_count) && $urandom_range(0, 6) == 0) begin
      out_stall = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge, predict on input, check on output
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    spoken_word_t exp_word;
    bit           moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        spell_number(value);
        in_count = in_count + 1;
        moved    = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (spoken_keys.size() == 0) begin
          $error("unexpected output word: word_key %0d last_word %0d", word_key, last_word);
          fail_count = fail_count + 1;
        end else begin
          exp_word      = spoken_keys.pop_front();
          words_checked = words_checked + 1;
          if (word_key !== exp_word.key) begin
            $error("word_key: expected %0d, got %0d", exp_word.key, word_key);
            fail_count = fail_count + 1;
          end
          if (last_word !== exp_word.is_last) begin
            $error("last_word: expected %0d, got %0d", exp_word.is_last, last_word);
            fail_count = fail_count + 1;
          end
        end
      end
      // watchdog: drop out if no word moves for too long
      if (moved) stuck_cycles = 0;
      else stuck_cycles = stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
        $display("FAIL number_to_word_keys_unit");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: fill the queue, release reset, wait for the run to drain
  // --------------------------------------------------------------------------
  initial begin
    longint unsigned wide;
    logic [nwk_pkg::VALUE_W-1:0] v;

    // directed: zero, the largest value, teens, tens, hundreds, every scale
    // and numbers with empty groups in between
    add_number(32'd0, 1'b0);
    add_number(32'hFFFF_FFFF, 1'b0);
    add_number(32'd1, 1'b0);
    add_number(32'd9, 1'b0);
    add_number(32'd10, 1'b0);
    add_number(32'd11, 1'b0);
    add_number(32'd19, 1'b0);
    add_number(32'd20, 1'b0);
    add_number(32'd21, 1'b0);
    add_number(32'd99, 1'b0);
    add_number(32'd100, 1'b0);
    add_number(32'd101, 1'b0);
    add_number(32'd120, 1'b0);
    add_number(32'd999, 1'b0);
    add_number(32'd1000, 1'b0);
    add_number(32'd1001, 1'b0);
    add_number(32'd100000, 1'b0);
    add_number(32'd700070, 1'b0);
    add_number(32'd1000000, 1'b0);
    add_number(32'd12345678, 1'b0);
    add_number(32'd19019019, 1'b0);
    add_number(32'd1000000000, 1'b0);
    add_number(32'd1000000001, 1'b0);
    add_number(32'd1001001001, 1'b0);
    add_number(32'd2000000000, 1'b0);

    // random: full-width values, small values, and numbers built group by
    // group so that empty groups turn up often
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      case ($urandom_range(0, 4))
        0: v = $urandom();
        1: v = $urandom_range(0, 999);
        2: v = $urandom_range(0, 999999);
        default: begin
          wide = longint'($urandom_range(0, 4)) * 1000000000 +
                 longint'(random_group()) * 1000000 +
                 longint'(random_group()) * 1000 +
                 longint'(random_group());
          if (wide > 64'hFFFF_FFFF) wide = wide - 1000000000;
          v = wide[nwk_pkg::VALUE_W-1:0];
        end
      endcase
      add_number(v, i == 0 || i == 60 || i == 130);
    end
    total_numbers = pending_numbers.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every number to go in, then for every key to come out
    while (pending_numbers.size() != 0 || in_count != sent_count) @(posedge clk);
    while (spoken_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Spelled %0d numbers into %0d checked word keys,", in_count, words_checked);
    $display("covering zero, the largest value, teens, tens and empty groups.");
    if (fail_count == 0 && spoken_keys.size() == 0) begin
      $display("PASS number_to_word_keys_unit");
    end else begin
      $display("FAIL number_to_word_keys_unit");
    end
    $finish;
  end

endmodule

[number_to_word_keys_unit.f]
src/nwk_pkg.sv
src/nwk_bcd_conv.sv
src/nwk_key_sel.sv
src/number_to_word_keys_unit.sv
src/nwk_checker.sv
tb/tb_number_to_word_keys_unit.sv
